### rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

    // default sizes for the top level parameters
    localparam int PAYLOAD_DEPTH_DEF = 256;
    localparam int MON_BYTES_DEF     = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_START    = 2'd0;
    localparam t_cfg_idx CFG_MON_TYPE = 2'd1;
    localparam t_cfg_idx CFG_MOT_TYPE = 2'd2;

    // configuration reset values
    localparam logic [7:0] START_RST    = 8'd170;
    localparam logic [7:0] MON_TYPE_RST = 8'd1;
    localparam logic [7:0] MOT_TYPE_RST = 8'd2;

    // frame classification reported with each result
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MON  = 2'd1,
        KIND_MOT  = 2'd2,
        KIND_UNK  = 2'd3
    } t_kind;

    // parser phase as reported on the output
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } t_phase;

    localparam int CNT_W = 32;

    // counter increment requests, one bit per statistic
    typedef struct packed {
        logic unknown;
        logic motor;
        logic monitoring;
        logic complete;
        logic ignored;
    } t_stat_inc;

    // counter values, ignored count in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] unknown;
        logic [CNT_W-1:0] motor;
        logic [CNT_W-1:0] monitoring;
        logic [CNT_W-1:0] complete;
        logic [CNT_W-1:0] ignored;
    } t_stat_cnt;

    // output stream layout
    localparam int BYTE_W     = 8;
    localparam int PHASE_W    = 3;
    localparam int TDATA_USED = BYTE_W + PHASE_W + 5 * CNT_W;
    localparam int TDATA_W    = ((TDATA_USED + 7) / 8) * 8;
    localparam int TDATA_PAD  = TDATA_W - TDATA_USED;
    localparam int TUSER_W    = 4;

endpackage
`default_nettype wire

### rtl/serial_frame_deframer_top.sv
`default_nettype none
// Serial frame deframer: takes one received byte per transfer and parses frames made of a
// start byte, a length byte, a type byte, that many payload bytes and a checksum byte (taken
// but not checked). Every byte gives one result from an output register; a new byte is taken
// in the same cycle as the pending result is taken, so plain bytes flow at one per cycle while
// results are not stalled. Payload bytes go into a PAYLOAD_DEPTH x 8 memory with a registered
// read. The checksum byte of a monitoring frame with at least MON_BYTES payload bytes instead
// gives a run of MON_BYTES results, read back one per cycle from the memory's single read port
// unless the output stalls; the input is held off until the last of them is loaded. The memory
// needs no clearing after reset. Counters and parser phase on each result are the values after
// its byte. Registers: 0 start marker, 1 monitoring type, 2 motor type.
module serial_frame_deframer_top #(
    parameter int PAYLOAD_DEPTH = sfd_pkg::PAYLOAD_DEPTH_DEF,
    parameter int MON_BYTES     = sfd_pkg::MON_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input bytes
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [7:0]                  i_s_axis_tdata,   // rx_byte
    // results
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // payload_byte, parser_phase, ignored_count, complete_count, monitoring_count,
    // motor_count, unknown_count, zero pad
    output logic [sfd_pkg::TDATA_W-1:0]      o_m_axis_tdata,
    // frame_end, frame_kind, payload_valid
    output logic [sfd_pkg::TUSER_W-1:0]      o_m_axis_tuser,
    output logic                             o_m_axis_tlast,   // last_of_run
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire sfd_pkg::t_cfg_idx           i_cfg_index,
    input  wire logic [7:0]                  i_cfg_data
);

    localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int FILL_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > 8) ? FILL_W : 8;
    localparam int K_W    = (MON_BYTES > 1) ? $clog2(MON_BYTES) : 1;
    localparam logic [K_W-1:0]    K_LAST    = K_W'(MON_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PAYLOAD_DEPTH);
    localparam logic [7:0]        MON_MIN   = 8'(MON_BYTES);

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_seq;

    // configuration
    logic [7:0]          r_start;
    logic [7:0]          r_mon_type;
    logic [7:0]          r_mot_type;

    // parser state
    sfd_pkg::t_phase     r_phase;
    logic [7:0]          r_len;
    logic [7:0]          r_type;
    logic [FILL_W-1:0]   r_fill;
    sfd_pkg::t_phase     n_phase;
    logic [7:0]          n_len;
    logic [7:0]          n_type;
    logic [FILL_W-1:0]   n_fill;

    // read-out sequencer and output register
    t_seq                r_seq;
    logic [K_W-1:0]      r_k;
    logic [K_W-1:0]      n_k;
    logic                r_out_valid;
    logic                r_out_end;
    sfd_pkg::t_kind      r_out_kind;
    logic                r_out_pv;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    // payload memory
    logic [7:0]          r_store [PAYLOAD_DEPTH];
    logic [7:0]          r_rd_data;
    logic                w_wr_en;
    logic                w_wr;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_addr;

    logic                w_in_xfer;
    logic                w_out_free;
    logic                w_load_run;
    logic                w_end;
    logic                w_run;
    sfd_pkg::t_kind      w_kind;
    sfd_pkg::t_stat_inc  w_inc;
    sfd_pkg::t_stat_inc  w_inc_xfer;
    sfd_pkg::t_stat_cnt  w_cnt;

    // handshakes
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_seq == S_IDLE) && w_out_free;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_load_run      = (r_seq == S_LOAD) && w_out_free;

    // parser next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_fill  = r_fill;
        w_wr    = 1'b0;
        w_end   = 1'b0;
        w_run   = 1'b0;
        w_kind  = sfd_pkg::KIND_NONE;
        w_inc   = '0;
        case (r_phase)
            sfd_pkg::PH_HUNT: begin
                if (i_s_axis_tdata == r_start) begin
                    n_phase = sfd_pkg::PH_LEN;
                end else begin
                    w_inc.ignored = 1'b1;
                end
            end
            sfd_pkg::PH_LEN: begin
                n_len   = i_s_axis_tdata;
                n_phase = sfd_pkg::PH_TYPE;
            end
            sfd_pkg::PH_TYPE: begin
                n_type  = i_s_axis_tdata;
                n_fill  = '0;
                n_phase = (r_len == 8'd0) ? sfd_pkg::PH_CSUM : sfd_pkg::PH_DATA;
            end
            sfd_pkg::PH_DATA: begin
                if (r_fill < FILL_FULL) begin
                    w_wr   = 1'b1;
                    n_fill = r_fill + FILL_W'(1);
                    if (CMP_W'(n_fill) >= CMP_W'(r_len)) begin
                        n_phase = sfd_pkg::PH_CSUM;
                    end
                end else begin
                    // store full: drop the frame
                    n_phase = sfd_pkg::PH_HUNT;
                    n_fill  = '0;
                end
            end
            sfd_pkg::PH_CSUM: begin
                w_end          = 1'b1;
                w_inc.complete = 1'b1;
                if (r_type == r_mon_type) begin
                    w_inc.monitoring = 1'b1;
                    w_kind           = sfd_pkg::KIND_MON;
                    w_run            = (r_len >= MON_MIN);
                end else if (r_type == r_mot_type) begin
                    w_inc.motor = 1'b1;
                    w_kind      = sfd_pkg::KIND_MOT;
                end else begin
                    w_inc.unknown = 1'b1;
                    w_kind        = sfd_pkg::KIND_UNK;
                end
                n_phase = sfd_pkg::PH_HUNT;
                n_fill  = '0;
                n_len   = 8'd0;
                n_type  = 8'd0;
            end
            default: begin
                n_phase = sfd_pkg::PH_HUNT;
            end
        endcase
    end

    assign w_inc_xfer = w_in_xfer ? w_inc : '0;

    // memory ports: writes only come from data bytes, reads only after the
    // checksum byte, so the same entry is never written and read in one cycle
    assign w_wr_en   = w_in_xfer && w_wr;
    assign w_wr_addr = r_fill[ADDR_W-1:0];
    assign n_k       = r_k + K_W'(1);
    assign w_rd_en   = (w_in_xfer && w_run) || (w_load_run && (r_k != K_LAST));
    assign w_rd_addr = w_in_xfer ? '0 : ADDR_W'(n_k);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= i_s_axis_tdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_store[w_rd_addr];
        end
    end

    // statistics
    sfd_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (w_inc_xfer),
        .o_cnt   (w_cnt)
    );

    // configuration, parser, sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= sfd_pkg::START_RST;
            r_mon_type  <= sfd_pkg::MON_TYPE_RST;
            r_mot_type  <= sfd_pkg::MOT_TYPE_RST;
            r_phase     <= sfd_pkg::PH_HUNT;
            r_len       <= 8'd0;
            r_type      <= 8'd0;
            r_fill      <= '0;
            r_seq       <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_out_end   <= 1'b0;
            r_out_kind  <= sfd_pkg::KIND_NONE;
            r_out_pv    <= 1'b0;
            r_out_byte  <= 8'd0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sfd_pkg::CFG_START:    r_start    <= i_cfg_data;
                    sfd_pkg::CFG_MON_TYPE: r_mon_type <= i_cfg_data;
                    sfd_pkg::CFG_MOT_TYPE: r_mot_type <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_xfer) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_type  <= n_type;
                r_fill  <= n_fill;
                if (w_run) begin
                    // first payload entry is being read, results follow
                    r_seq       <= S_LOAD;
                    r_k         <= '0;
                    r_out_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b1;
                    r_out_end   <= w_end;
                    r_out_kind  <= w_kind;
                    r_out_pv    <= 1'b0;
                    r_out_byte  <= 8'd0;
                    r_out_last  <= 1'b1;
                end
            end else if (w_load_run) begin
                // one monitoring byte per transfer
                r_out_valid <= 1'b1;
                r_out_end   <= 1'b1;
                r_out_kind  <= sfd_pkg::KIND_MON;
                r_out_pv    <= 1'b1;
                r_out_byte  <= r_rd_data;
                r_out_last  <= (r_k == K_LAST);
                if (r_k == K_LAST) begin
                    r_seq <= S_IDLE;
                end else begin
                    r_k <= n_k;
                end
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // counters and phase only move on an input transfer, which needs the
    // output slot free, so they stay put while a result waits
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{sfd_pkg::TDATA_PAD{1'b0}}, w_cnt, r_phase, r_out_byte};
    assign o_m_axis_tuser  = {r_out_pv, r_out_kind, r_out_end};
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

### rtl/sfd_stats.sv
`default_nettype none
module sfd_stats (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfd_pkg::t_stat_inc i_inc,
    output sfd_pkg::t_stat_cnt     o_cnt
);

    sfd_pkg::t_stat_cnt r_cnt;

    // wrapping statistics counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_inc.ignored)    r_cnt.ignored    <= r_cnt.ignored + 32'd1;
            if (i_inc.complete)   r_cnt.complete   <= r_cnt.complete + 32'd1;
            if (i_inc.monitoring) r_cnt.monitoring <= r_cnt.monitoring + 32'd1;
            if (i_inc.motor)      r_cnt.motor      <= r_cnt.motor + 32'd1;
            if (i_inc.unknown)    r_cnt.unknown    <= r_cnt.unknown + 32'd1;
        end
    end

    assign o_cnt = r_cnt;

endmodule
`default_nettype wire

### rtl/sfd_chk.sv
`default_nettype none
module sfd_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_axis_tvalid,
    input wire logic                        o_s_axis_tready,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [sfd_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [sfd_pkg::TUSER_W-1:0] o_m_axis_tuser,
    input wire logic                        o_m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // payload bytes only come from a finished monitoring frame
    a_pv_mon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[3] |->
            o_m_axis_tuser[0] && (o_m_axis_tuser[2:1] == sfd_pkg::KIND_MON))
        else $error("payload byte outside a monitoring frame end");

    // only a monitoring run has results before its last one
    a_run_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser[3])
        else $error("non-last result without payload byte");

    // input held off while a run is being delivered
    a_run_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input taken during a monitoring run");

    // a frame end leaves the parser hunting
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            (o_m_axis_tdata[10:8] == sfd_pkg::PH_HUNT))
        else $error("frame end with parser not hunting");

endmodule

bind serial_frame_deframer_top sfd_chk u_sfd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

### bench/serial_frame_deframer_top_tb.sv
`timescale 1ns / 1ps

module serial_frame_deframer_top_tb;
    import sfd_pkg::*;

    localparam int          DEPTH     = PAYLOAD_DEPTH_DEF;
    localparam int          MON_RUN   = MON_BYTES_DEF;
    localparam int          SETTLE    = MON_RUN + 4;
    localparam int unsigned LIMIT     = 600000;
    localparam t_cfg_idx    CFG_SPARE = 2'd3;

    // one expected result, fields as the block reports them
    typedef struct {
        logic       frame_end;
        t_kind      kind;
        logic       pay_valid;
        logic [7:0] pay_byte;
        logic       last;
        t_phase     phase;
        t_stat_cnt  cnt;
    } frame_result_t;

    // frame parser prediction and result checking
    class frame_scoreboard;
        logic [7:0]    start_marker;
        logic [7:0]    mon_code;
        logic [7:0]    mot_code;
        t_phase        phase;
        logic [7:0]    frame_length;
        logic [7:0]    frame_type;
        int unsigned   fill_index;
        logic [7:0]    payload_mem [DEPTH];
        t_stat_cnt     stats;
        frame_result_t pending_results [$];
        int unsigned   errors;
        int unsigned   results_checked;

        function new();
            start_marker    = START_RST;
            mon_code        = MON_TYPE_RST;
            mot_code        = MOT_TYPE_RST;
            phase           = PH_HUNT;
            frame_length    = 8'd0;
            frame_type      = 8'd0;
            fill_index      = 0;
            stats           = '0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] value);
            case (idx)
                CFG_START:    start_marker = value;
                CFG_MON_TYPE: mon_code = value;
                CFG_MOT_TYPE: mot_code = value;
                default: ;
            endcase
        endfunction

        // advance the parser by one accepted byte and queue what it yields
        function void note_byte(logic [7:0] rx);
            logic [7:0]    len_done;
            logic          is_end;
            logic          is_run;
            t_kind         kind;
            frame_result_t res;
            len_done = frame_length;
            is_end   = 1'b0;
            is_run   = 1'b0;
            kind     = KIND_NONE;
            case (phase)
                PH_HUNT: begin
                    if (rx == start_marker) phase = PH_LEN;
                    else stats.ignored += 1;
                end
                PH_LEN: begin
                    frame_length = rx;
                    phase        = PH_TYPE;
                end
                PH_TYPE: begin
                    frame_type = rx;
                    fill_index = 0;
                    phase      = (frame_length == 8'd0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA: begin
                    // a full store drops the byte and restarts the hunt
                    if (fill_index < DEPTH) begin
                        payload_mem[fill_index] = rx;
                        fill_index++;
                        if (fill_index >= frame_length) phase = PH_CSUM;
                    end else begin
                        phase      = PH_HUNT;
                        fill_index = 0;
                    end
                end
                PH_CSUM: begin
                    // monitoring wins when both type codes match
                    is_end = 1'b1;
                    stats.complete += 1;
                    if (frame_type == mon_code) begin
                        stats.monitoring += 1;
                        kind   = KIND_MON;
                        is_run = (len_done >= MON_RUN);
                    end else if (frame_type == mot_code) begin
                        stats.motor += 1;
                        kind = KIND_MOT;
                    end else begin
                        stats.unknown += 1;
                        kind = KIND_UNK;
                    end
                    phase        = PH_HUNT;
                    fill_index   = 0;
                    frame_length = 8'd0;
                    frame_type   = 8'd0;
                end
                default: phase = PH_HUNT;
            endcase

            res.frame_end = is_end;
            res.kind      = kind;
            res.phase     = phase;
            res.cnt       = stats;
            if (!is_run) begin
                res.pay_valid = 1'b0;
                res.pay_byte  = 8'd0;
                res.last      = 1'b1;
                pending_results.push_back(res);
            end else begin
                for (int k = 0; k < MON_RUN; k++) begin
                    res.pay_valid = 1'b1;
                    res.pay_byte  = (k < DEPTH) ? payload_mem[k] : 8'd0;
                    res.last      = (k == MON_RUN - 1);
                    pending_results.push_back(res);
                end
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one output transfer with the oldest expectation
        function void check_result(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser,
                                   logic tlast);
            frame_result_t want;
            t_stat_cnt     got_cnt;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result tdata %0h tuser %0h tlast %0b",
                         $time, tdata, tuser, tlast);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            got_cnt = tdata[BYTE_W+PHASE_W +: 5*CNT_W];
            cmp_field("frame_end", want.frame_end, tuser[0]);
            cmp_field("frame_kind", want.kind, tuser[2:1]);
            cmp_field("payload_valid", want.pay_valid, tuser[3]);
            cmp_field("payload_byte", want.pay_byte, tdata[7:0]);
            cmp_field("last_of_run", want.last, tlast);
            cmp_field("parser_phase", want.phase, tdata[BYTE_W +: PHASE_W]);
            cmp_field("ignored_count", want.cnt.ignored, got_cnt.ignored);
            cmp_field("complete_count", want.cnt.complete, got_cnt.complete);
            cmp_field("monitoring_count", want.cnt.monitoring, got_cnt.monitoring);
            cmp_field("motor_count", want.cnt.motor, got_cnt.motor);
            cmp_field("unknown_count", want.cnt.unknown, got_cnt.unknown);
            cmp_field("tdata pad", 32'd0, tdata[TDATA_W-1:TDATA_USED]);
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_valid   = 1'b0;
    logic [7:0]          s_data    = 8'd0;
    logic                m_ready   = 1'b0;
    logic                cfg_valid = 1'b0;
    t_cfg_idx            cfg_idx   = CFG_START;
    logic [7:0]          cfg_data  = 8'd0;
    logic                s_ready;
    logic                m_valid;
    logic [TDATA_W-1:0]  m_data;
    logic [TUSER_W-1:0]  m_user;
    logic                m_last;
    logic                cfg_ready;

    bit                  src_idle   = 1'b0;
    bit                  snk_idle   = 1'b0;
    int unsigned         bytes_sent = 0;
    int unsigned         cycle_count = 0;
    frame_scoreboard     sb = new();

    serial_frame_deframer_top #(
        .PAYLOAD_DEPTH(DEPTH),
        .MON_BYTES    (MON_RUN)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // watch both streams at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_valid && m_ready) sb.check_result(m_data, m_user, m_last);
            if (s_valid && s_ready) sb.note_byte(s_data);
        end
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned gap_draw(bit on);
        return on ? $urandom_range(0, 17) : 0;
    endfunction

    // result side back-pressure
    initial begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = gap_draw(snk_idle);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // one byte transfer, called and returning at a falling edge
    task automatic send_byte(input logic [7:0] rx);
        int unsigned gap;
        gap = gap_draw(src_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= rx;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // hold the input until every queued result is out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] start, input logic [7:0] mon,
                              input logic [7:0] mot, input bit poke_spare);
        cfg_write(CFG_START, start);
        cfg_write(CFG_MON_TYPE, mon);
        cfg_write(CFG_MOT_TYPE, mot);
        // the spare index must leave every setting alone
        if (poke_spare) cfg_write(CFG_SPARE, 8'hA5);
        cfg_valid <= 1'b0;
    endtask

    // start, length, type, n payload bytes, checksum only when complete
    task automatic send_frame(input int unsigned len, input logic [7:0] ftype,
                              input int unsigned n_payload);
        send_byte(sb.start_marker);
        send_byte(8'(len));
        send_byte(ftype);
        repeat (n_payload) send_byte(8'($urandom_range(0, 255)));
        if (n_payload == len) send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_type();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return sb.mon_code;
        if (r < 7) return sb.mot_code;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, MON_RUN + 4);
        if (r < 9) return $urandom_range(MON_RUN, 40);
        return $urandom_range(0, 3);
    endfunction

    // mostly whole frames, some noise and cut-off frames
    task automatic run_random(input int unsigned budget, input bit mid_drain);
        int unsigned used;
        int unsigned pick;
        int unsigned len;
        int unsigned part;
        bit          drained;
        used    = 0;
        drained = 1'b0;
        while (used < budget) begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            pick     = $urandom_range(0, 9);
            if (pick < 8) begin
                len = pick_len();
                send_frame(len, pick_type(), len);
                used += len + 4;
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                len  = $urandom_range(4, 20);
                part = $urandom_range(0, len - 1);
                send_frame(len, pick_type(), part);
                used += part + 3;
            end
            if (mid_drain && !drained && used >= budget / 2) begin
                drain_results();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames at the reset settings
        send_byte(8'h00); send_byte(8'hFF);
        // zero length motor frame
        send_byte(START_RST); send_byte(8'd0); send_byte(MOT_TYPE_RST); send_byte(8'h00);
        // monitoring frame shorter than a run
        send_byte(START_RST); send_byte(8'd3); send_byte(MON_TYPE_RST);
        send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'hFF);
        // monitoring frame of exactly one run
        send_byte(START_RST); send_byte(8'(MON_RUN)); send_byte(MON_TYPE_RST);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h80);
        send_byte(8'h7F); send_byte(8'h55); send_byte(8'hAA); send_byte(8'h0F);
        send_byte(8'h3C);
        // unknown type
        send_byte(START_RST); send_byte(8'd0); send_byte(8'hFE); send_byte(8'h00);

        // equal type codes, zero start marker
        drain_results();
        set_config(8'h00, 8'hFF, 8'hFF, 1'b0);
        run_random(20, 1'b1);

        // opposite extremes plus the longest frame
        drain_results();
        set_config(8'hFF, 8'h00, 8'h7F, 1'b1);
        send_frame(255, sb.mon_code, 255);
        run_random(20, 1'b0);

        // random settings
        drain_results();
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0);
        run_random(20, 1'b0);

        drain_results();
        $display("sent %0d bytes, checked %0d results over four register settings",
                 bytes_sent, sb.results_checked);
        $display("frames: %0d complete, %0d monitoring, %0d motor, %0d unknown, %0d ignored",
                 sb.stats.complete, sb.stats.monitoring, sb.stats.motor, sb.stats.unknown,
                 sb.stats.ignored);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
